// File: hw/rtl/nrc_pkg.sv
// nrc_pkg: shared types and constants of the noc route compute block
// no dependencies; used by the route logic, the top level and the checker
package nrc_pkg;

    // routing algorithm, from the route_mode register
    typedef enum logic [1:0] {
        MODE_TORUS      = 2'd0,
        MODE_MESH_YX    = 2'd1,
        MODE_CHIP_MESH  = 2'd2,
        MODE_CHIP_STAR  = 2'd3
    } t_mode;

    // configuration register indexes
    localparam logic [2:0] REG_ROUTE_MODE = 3'd0;
    localparam logic [2:0] REG_RING_SIZE  = 3'd1;
    localparam logic [2:0] REG_CHIP_X     = 3'd2;
    localparam logic [2:0] REG_CHIP_Y     = 3'd3;
    localparam logic [2:0] REG_CORE_X     = 3'd4;
    localparam logic [2:0] REG_CORE_Y     = 3'd5;

    // output port codes
    localparam logic [7:0] PORT_EJECT   = 8'd0;
    localparam logic [7:0] PORT_CHIP_XN = 8'd1;
    localparam logic [7:0] PORT_CHIP_XP = 8'd2;
    localparam logic [7:0] PORT_CHIP_YN = 8'd3;
    localparam logic [7:0] PORT_CHIP_YP = 8'd4;
    localparam logic [7:0] PORT_CORE_XN = 8'd5;
    localparam logic [7:0] PORT_CORE_XP = 8'd6;
    localparam logic [7:0] PORT_CORE_YN = 8'd7;
    localparam logic [7:0] PORT_CORE_YP = 8'd8;
    localparam logic [7:0] PORT_HUB     = 8'd9;
    localparam logic [7:0] PORT_MAX     = 8'd255;

    // reset values of the configuration registers
    localparam t_mode      RST_MODE   = MODE_MESH_YX;
    localparam int         RST_RING   = 4;
    localparam logic [3:0] RST_COORD  = 4'd0;

    typedef struct packed {
        logic [3:0] dest_chiplet_x;
        logic [3:0] dest_chiplet_y;
        logic [3:0] dest_core_x;
        logic [3:0] dest_core_y;
        logic [3:0] in_port;
        logic [2:0] in_vc;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_port;
        logic [1:0] out_vc;
        logic [3:0] src_port_echo;
        logic [2:0] src_vc_echo;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [2:0] reg_index;
        logic [4:0] wr_data;
    } t_cfg_item;

    // route decision handed from the route logic to the result stage
    typedef struct packed {
        logic [7:0] port;
        logic [1:0] last_idx;   // number of candidates minus one
        logic [1:0] vc0;        // vc of the first candidate
    } t_route;

endpackage

// File: hw/rtl/nrc_stream_if.sv
// nrc_stream_if: valid/ready channel carrying one payload item per handshake
// payload type is a parameter; used with the types of nrc_pkg
interface nrc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/nrc_route_logic.sv
// nrc_route_logic: combinational route decision for one header item
// depends on nrc_pkg for item, mode and route types
module nrc_route_logic import nrc_pkg::*; #(
    parameter int MAX_RING = 16
) (
    input  t_in_item                        i_item,
    input  t_mode                           i_mode,
    input  logic [$clog2(MAX_RING+1)-1:0]   i_ring,
    input  logic [3:0]                      i_chip_x,
    input  logic [3:0]                      i_chip_y,
    input  logic [3:0]                      i_core_x,
    input  logic [3:0]                      i_core_y,
    output t_route                          o_route
);
    localparam int RING_W = $clog2(MAX_RING+1);
    localparam int CMP_W  = (RING_W > 5) ? RING_W : 5;
    localparam int PW     = (RING_W + 5 > 9) ? RING_W + 5 : 9;

    logic signed [4:0] d0, d1, d2, d3;
    logic [3:0]        a0, a1;
    logic              xs, ys, centre, gateway;
    logic [RING_W-1:0] c_m1;
    logic [PW-1:0]     p_full;
    logic [7:0]        p_sat;

    assign d0 = $signed({1'b0, i_item.dest_chiplet_x}) - $signed({1'b0, i_chip_x});
    assign d1 = $signed({1'b0, i_item.dest_chiplet_y}) - $signed({1'b0, i_chip_y});
    assign d2 = $signed({1'b0, i_item.dest_core_x}) - $signed({1'b0, i_core_x});
    assign d3 = $signed({1'b0, i_item.dest_core_y}) - $signed({1'b0, i_core_y});

    assign a0 = d0[4] ? 4'(-d0) : 4'(d0);
    assign a1 = d1[4] ? 4'(-d1) : 4'(d1);

    // short way around the ring when twice the offset fits in it
    assign xs = CMP_W'({a0, 1'b0}) <= CMP_W'(i_ring);
    assign ys = CMP_W'({a1, 1'b0}) <= CMP_W'(i_ring);

    assign gateway = (i_core_x == 4'd0) && (i_core_y == 4'd0);
    // star centre sits at (ring-1, ring-1, 0, 0); a ring of zero has none
    assign centre  = (CMP_W'(i_chip_x) + CMP_W'(1) == CMP_W'(i_ring)) &&
                     (CMP_W'(i_chip_y) + CMP_W'(1) == CMP_W'(i_ring)) && gateway;
    assign c_m1    = i_ring - RING_W'(1);
    assign p_full  = PW'(i_item.dest_chiplet_x) * PW'(c_m1) +
                     PW'(i_item.dest_chiplet_y) + PW'(1);
    assign p_sat   = (p_full > PW'(PORT_MAX)) ? PORT_MAX : p_full[7:0];

    always_comb begin
        o_route = '{port: PORT_EJECT, last_idx: 2'd0, vc0: 2'd0};
        if ((i_mode == MODE_TORUS || i_mode == MODE_MESH_YX) ? (d0 == 0 && d1 == 0)
                : (d0 == 0 && d1 == 0 && d2 == 0 && d3 == 0)) begin
            o_route = '{port: PORT_EJECT, last_idx: 2'd0, vc0: 2'd0};
        end else begin
            unique case (i_mode)
                MODE_TORUS: begin
                    if (d0 != 0) begin
                        o_route.port = (xs ^ d0[4]) ? PORT_CHIP_XP : PORT_CHIP_XN;
                        o_route.vc0  = d0[4] ? 2'd0 : 2'd1;
                    end else begin
                        o_route.port = (ys ^ d1[4]) ? PORT_CHIP_YP : PORT_CHIP_YN;
                        o_route.vc0  = d1[4] ? 2'd0 : 2'd1;
                    end
                    o_route.last_idx = 2'd0;
                end
                MODE_MESH_YX: begin
                    if (d1 != 0) begin
                        o_route.port = d1[4] ? PORT_CHIP_YN : PORT_CHIP_YP;
                    end else begin
                        o_route.port = d0[4] ? PORT_CHIP_XN : PORT_CHIP_XP;
                    end
                    o_route.last_idx = 2'd3;
                end
                MODE_CHIP_MESH, MODE_CHIP_STAR: begin
                    o_route.last_idx = 2'd1;
                    if (i_mode == MODE_CHIP_STAR && centre) begin
                        o_route.port = p_sat;
                    end else if (d0 == 0 && d1 == 0) begin
                        if (d2 != 0) begin
                            o_route.port = d2[4] ? PORT_CORE_XN : PORT_CORE_XP;
                        end else begin
                            o_route.port = d3[4] ? PORT_CORE_YN : PORT_CORE_YP;
                        end
                    end else if (gateway) begin
                        if (i_mode == MODE_CHIP_STAR) begin
                            o_route.port = PORT_HUB;
                        end else if (d0 == 0) begin
                            o_route.port = d1[4] ? PORT_CHIP_YN : PORT_CHIP_YP;
                        end else begin
                            o_route.port = d0[4] ? PORT_CHIP_XN : PORT_CHIP_XP;
                        end
                    end else begin
                        o_route.port = (i_core_x != 4'd0) ? PORT_CORE_XN : PORT_CORE_YN;
                    end
                end
                default: o_route = '{port: PORT_EJECT, last_idx: 2'd0, vc0: 2'd0};
            endcase
        end
    end
endmodule

// File: hw/rtl/noc_route_compute_unit.sv
// noc_route_compute_unit: top level of the router route computation block
// depends on nrc_pkg, nrc_stream_if and nrc_route_logic
//
// channel   dir  modport  payload      handshake
// i_item    in   sink     t_in_item    valid & ready, one header item
// o_cand    out  source   t_out_item   valid & ready, one candidate item
// i_cfg     in   sink     t_cfg_item   valid & ready, ready always high
//
// an accepted item lands in the input register, and its route decision is taken
// into the result register once that register frees. the result register then
// emits the run of candidates (1 for eject and torus, 2 for chiplet modes, 4 for
// mesh), one candidate a cycle while o_cand is ready. the input register refills
// while a run is emitted. i_rst_n is synchronous: it drops both valid flags and
// loads the config reset values. a stall on o_cand holds the candidate and backs
// up into i_item once the input register is full
module noc_route_compute_unit import nrc_pkg::*; #(
    parameter int MAX_RING = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    nrc_stream_if.sink           i_item,
    nrc_stream_if.source         o_cand,
    nrc_stream_if.sink           i_cfg
);
    localparam int RING_W   = $clog2(MAX_RING+1);
    localparam int CMP_W    = (RING_W > 5) ? RING_W : 5;
    localparam int RING_RST = (RST_RING > MAX_RING) ? MAX_RING : RST_RING;

    // configuration registers
    t_mode             r_mode;
    logic [RING_W-1:0] r_ring;
    logic [3:0]        r_chip_x, r_chip_y, r_core_x, r_core_y;

    // input register
    logic              r_s1_vld;
    t_in_item          r_s1_item;

    // result register
    logic              r_s2_vld;
    t_route            r_s2_route;
    logic [3:0]        r_s2_port;
    logic [2:0]        r_s2_vc;
    logic [1:0]        r_k;

    t_route            w_route;
    logic              w_out_valid, w_out_ready, w_out_last;
    t_out_item         w_out_data;
    logic              w_out_fire, w_s2_free, w_s1_adv, w_in_ready, w_in_fire;
    logic              w_cfg_fire;

    // ---------------- configuration port ----------------
    assign i_cfg.ready = 1'b1;
    assign w_cfg_fire  = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= RST_MODE;
            r_ring   <= RING_W'(RING_RST);
            r_chip_x <= RST_COORD;
            r_chip_y <= RST_COORD;
            r_core_x <= RST_COORD;
            r_core_y <= RST_COORD;
        end else if (w_cfg_fire) begin
            unique case (i_cfg.data.reg_index)
                REG_ROUTE_MODE: r_mode <= t_mode'(i_cfg.data.wr_data[1:0]);
                REG_RING_SIZE: begin
                    // clamp ring size to the supported maximum
                    if (CMP_W'(i_cfg.data.wr_data) > CMP_W'(MAX_RING)) begin
                        r_ring <= RING_W'(MAX_RING);
                    end else begin
                        r_ring <= RING_W'(i_cfg.data.wr_data);
                    end
                end
                REG_CHIP_X: r_chip_x <= i_cfg.data.wr_data[3:0];
                REG_CHIP_Y: r_chip_y <= i_cfg.data.wr_data[3:0];
                REG_CORE_X: r_core_x <= i_cfg.data.wr_data[3:0];
                REG_CORE_Y: r_core_y <= i_cfg.data.wr_data[3:0];
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // ---------------- flow control ----------------
    assign w_out_ready = o_cand.ready;
    assign w_out_valid = r_s2_vld;
    assign w_out_last  = (r_k == r_s2_route.last_idx);
    assign w_out_fire  = w_out_valid & w_out_ready;
    // result register frees when empty or its last candidate leaves now
    assign w_s2_free   = !r_s2_vld | (w_out_fire & w_out_last);
    assign w_s1_adv    = r_s1_vld & w_s2_free;
    assign w_in_ready  = !r_s1_vld | w_s2_free;
    assign w_in_fire   = i_item.valid & w_in_ready;
    assign i_item.ready = w_in_ready;

    // ---------------- input register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_in_fire) begin
            r_s1_vld <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_item <= i_item.data;
        end
    end

    // ---------------- route decision ----------------
    nrc_route_logic #(
        .MAX_RING (MAX_RING)
    ) u_route (
        .i_item   (r_s1_item),
        .i_mode   (r_mode),
        .i_ring   (r_ring),
        .i_chip_x (r_chip_x),
        .i_chip_y (r_chip_y),
        .i_core_x (r_core_x),
        .i_core_y (r_core_y),
        .o_route  (w_route)
    );

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_k      <= 2'd0;
        end else if (w_s2_free) begin
            r_s2_vld <= r_s1_vld;
            r_k      <= 2'd0;
        end else if (w_out_fire) begin
            r_k      <= r_k + 2'd1;   // step to the next candidate vc
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_s2_route <= w_route;
            r_s2_port  <= r_s1_item.in_port;
            r_s2_vc    <= r_s1_item.in_vc;
        end
    end

    // first candidate carries the decided vc, later ones count up
    always_comb begin
        w_out_data.out_port      = r_s2_route.port;
        w_out_data.out_vc        = (r_k == 2'd0) ? r_s2_route.vc0 : r_k;
        w_out_data.src_port_echo = r_s2_port;
        w_out_data.src_vc_echo   = r_s2_vc;
        w_out_data.last          = w_out_last;
    end

    assign o_cand.valid = w_out_valid;
    assign o_cand.data  = w_out_data;

endmodule

// File: hw/rtl/nrc_checker.sv
// nrc_checker: port-level checks of the noc route compute block
// depends on nrc_pkg; bound to noc_route_compute_unit below
module nrc_checker import nrc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);
    // a stalled candidate holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("candidate changed under stall");

    // within a run the port and echoes stay, the vc counts up
    a_run_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_data.last |=>
            i_out_valid && i_out_data.out_port == $past(i_out_data.out_port) &&
            i_out_data.out_vc == 2'($past(i_out_data.out_vc) + 2'd1) &&
            i_out_data.src_port_echo == $past(i_out_data.src_port_echo) &&
            i_out_data.src_vc_echo == $past(i_out_data.src_vc_echo))
        else $error("run broken between candidates");

    // eject is always a single candidate on vc 0
    a_eject_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.out_port == PORT_EJECT |->
            i_out_data.last && i_out_data.out_vc == 2'd0)
        else $error("eject not a single vc 0 candidate");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");
endmodule

bind noc_route_compute_unit nrc_checker u_nrc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (w_out_valid),
    .i_out_ready (w_out_ready),
    .i_out_data  (w_out_data)
);
